// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define EXPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EXPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EXPS_ASSERT(label, clk, rst_n, prop, msg)
`define EXPS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/exps_pkg.sv =====
// Shared types and codes for the exponential search block.
// No dependencies.
package exps_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned COUNT_W = 11;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK0,
        ST_DBL,
        ST_RANGE,
        ST_BIN,
        ST_BCMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_exps_status;

endpackage

// ===== hw/rtl/exponential_search_top.sv =====
// Exponential search block: top level joining the sequencer and the table.
// Depends on exps_pkg, exps_mem, exps_seq and assert_macros.svh.
//
// Usage:
// Input channel (i_valid / o_stall) carries one word per item. i_op selects
// a table write (i_entry_address, i_write_value) or a search (i_search_key).
// Writes give no result; addresses at or beyond
// TABLE_DEPTH are dropped. Each search gives one result word (o_found,
// o_position) on the output channel (o_valid / i_stall).
// A search checks entry 0, then makes doubling probes (one table read per cycle,
// at most log2(TABLE_DEPTH)) while the entry is below the key, then binary
// probes over the bracketed range (address state plus compare state each),
// all through the single table read port. An empty table goes straight to
// the result.
// The block holds one search at a time; o_stall is high while it runs.
// A result waits in the output register while i_stall is high; the next
// item is taken meanwhile, and a later result holds until the register frees.
// The entry count register (i_cfg_data) is written through i_cfg_valid /
// o_cfg_ready when idle, by the user; the block does not enforce it. Reset
// clears the count and channels; table contents are undefined until written.
module exponential_search_top
    import exps_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [ADDR_W-1:0]   i_entry_address,
    input  logic [KEY_W-1:0]    i_write_value,
    input  logic [KEY_W-1:0]    i_search_key,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_found,
    output logic [ADDR_W-1:0]   o_position
);

    `include "assert_macros.svh"

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [KEY_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [KEY_W-1:0]  mem_rdata;
    t_exps_status      status;

    assign o_cfg_ready = 1'b1;

    exps_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_entry_address (i_entry_address),
        .i_write_value   (i_write_value),
        .i_search_key    (i_search_key),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_found         (o_found),
        .o_position      (o_position),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata),
        .o_status        (status)
    );

    exps_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    `EXPS_ASSERT(a_search_starts, i_clk, i_rst_n, (i_valid && !o_stall && i_op == OP_SEARCH) |=> status.busy, "search item did not start the sequencer")
    `EXPS_ASSERT_NEVER(a_write_while_busy, i_clk, i_rst_n, mem_we && status.busy, "table write during a search")
    `EXPS_ASSERT(a_done_delivers, i_clk, i_rst_n, (status.done && (!o_valid || !i_stall)) |=> o_valid, "finished search not moved to output")
    `EXPS_ASSERT_NEVER(a_miss_pos_zero, i_clk, i_rst_n, o_valid && !o_found && (o_position != '0), "miss with nonzero position")

endmodule

// ===== hw/rtl/exps_mem.sv =====
// Entry table: one write port, one read port with registered read data.
// Depends on exps_pkg.
module exps_mem
    import exps_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024,
    localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [KEY_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [KEY_W-1:0]  o_rdata
);

    logic [KEY_W-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/exps_seq.sv =====
// Search sequencer: count register, probe FSM and the result register.
// Depends on exps_pkg; drives the ports of exps_mem.
module exps_seq
    import exps_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024,
    localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [COUNT_W-1:0]  i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [ADDR_W-1:0]   i_entry_address,
    input  logic [KEY_W-1:0]    i_write_value,
    input  logic [KEY_W-1:0]    i_search_key,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_found,
    output logic [ADDR_W-1:0]   o_position,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output logic [KEY_W-1:0]    o_mem_wdata,
    output logic                o_mem_re,
    output logic [AW-1:0]       o_mem_raddr,
    input  logic [KEY_W-1:0]    i_mem_rdata,
    output t_exps_status        o_status
);

    // index width: doubling may reach twice the last position
    localparam int unsigned IW  = AW + 1;
    localparam int unsigned CXW = (IW > COUNT_W) ? IW : COUNT_W;
    localparam int unsigned PXW = (IW > ADDR_W) ? IW : ADDR_W;

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_entry_count;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [IW-1:0]       r_n, n_n;
    logic [IW-1:0]       r_i, n_i;
    logic [IW-1:0]       r_lo, n_lo;
    logic [IW-1:0]       r_hi, n_hi;
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_pos, n_pos;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [ADDR_W-1:0]   r_out_pos, n_out_pos;

    logic                accept;
    logic [IW-1:0]       eff_n;
    logic [IW-1:0]       i_dbl;
    logic [IW-1:0]       hi_lim;
    logic [IW-1:0]       mid;
    logic signed [KEY_W-1:0] rd_s, key_s;
    logic                out_free;

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign eff_n = (CXW'(r_entry_count) > CXW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH)
                                                             : IW'(r_entry_count);
    assign i_dbl  = IW'({r_i, 1'b0});
    assign hi_lim = ((r_i - IW'(1)) > (r_n - IW'(1))) ? (r_n - IW'(1)) : (r_i - IW'(1));
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign rd_s   = $signed(i_mem_rdata);
    assign key_s  = $signed(r_key);

    assign o_mem_waddr = AW'(i_entry_address);
    assign o_mem_wdata = i_write_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_n         <= n_n;
        r_i         <= n_i;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_hit       <= n_hit;
        r_pos       <= n_pos;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_n         = r_n;
        n_i         = r_i;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_hit       = r_hit;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_stall;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_WRITE) begin
                        o_mem_we = PXW'(i_entry_address) < PXW'(TABLE_DEPTH);
                    end else begin
                        n_key = i_search_key;
                        n_n   = eff_n;
                        n_hit = 1'b0;
                        n_pos = '0;
                        if (eff_n == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            o_mem_re = 1'b1;
                            n_state  = ST_CHK0;
                        end
                    end
                end
            end
            ST_CHK0: begin
                if (rd_s == key_s) begin
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_i = IW'(1);
                    if (IW'(1) < r_n) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(1);
                        n_state     = ST_DBL;
                    end else begin
                        n_state = ST_RANGE;
                    end
                end
            end
            ST_DBL: begin
                // word at r_i is in; r_i < r_n holds here
                if (rd_s < key_s) begin
                    n_i = i_dbl;
                    if (i_dbl < r_n) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(i_dbl);
                    end else begin
                        n_state = ST_RANGE;
                    end
                end else if (rd_s == key_s) begin
                    n_hit   = 1'b1;
                    n_pos   = r_i;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RANGE;
                end
            end
            ST_RANGE: begin
                n_lo    = (r_i >> 1) + IW'(1);
                n_hi    = hi_lim;
                n_state = ST_BIN;
            end
            ST_BIN: begin
                if (r_lo > r_hi) begin
                    n_state = ST_DONE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(mid);
                    n_i         = mid;
                    n_state     = ST_BCMP;
                end
            end
            ST_BCMP: begin
                // mid >= 1, so mid - 1 never wraps
                if (rd_s == key_s) begin
                    n_hit   = 1'b1;
                    n_pos   = r_i;
                    n_state = ST_DONE;
                end else if (rd_s < key_s) begin
                    n_lo    = r_i + IW'(1);
                    n_state = ST_BIN;
                end else begin
                    n_hi    = r_i - IW'(1);
                    n_state = ST_BIN;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_hit;
                    n_out_pos   = r_hit ? ADDR_W'(r_pos) : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.done = (r_state == ST_DONE);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for exponential_search_top: table writes and key searches, each result word
// checked against a search model of the table kept inside the bench.
// Depends on exps_pkg and the exponential search RTL.
module tb;
    import exps_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int KEY_MIN     = 32'sh8000_0000;
    localparam int KEY_MAX     = 32'sh7FFF_FFFF;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 1900;
    localparam int CALM_TAIL   = 250;
    localparam int PREFIX      = 64;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] position;
    } t_search_answer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [COUNT_W-1:0]  i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_op = OP_WRITE;
    logic [ADDR_W-1:0]   i_entry_address = '0;
    logic [KEY_W-1:0]    i_write_value = '0;
    logic [KEY_W-1:0]    i_search_key = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_found;
    logic [ADDR_W-1:0]   o_position;

    int             entries_shadow [DEPTH];
    int             base_values [DEPTH];
    int unsigned    count_shadow = 0;
    t_search_answer answers_due [$];
    int             fail_count = 0;
    int             items_sent = 0;
    int             idle_pct = 0;
    int             stall_pct = 0;
    bit             calm = 1'b0;
    bit             long_hold_pending = 1'b0;
    bit             prefix_dirty = 1'b0;
    int             quiet_cycles = 0;

    exponential_search_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_entry_address(i_entry_address),
        .i_write_value  (i_write_value),
        .i_search_key   (i_search_key),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_position     (o_position)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Exponential probe then clipped binary search over the shadow table.
    function automatic t_search_answer predict_search(input int key);
        t_search_answer ans;
        int n;
        int i;
        int lo;
        int hi;
        int mid;
        ans = '0;
        n = (count_shadow > DEPTH) ? DEPTH : int'(count_shadow);
        if (n > 0) begin
            if (entries_shadow[0] == key) begin
                ans.found = 1'b1;
            end else begin
                i = 1;
                while (i < n && entries_shadow[i] < key) i = i * 2;
                if (i < n && entries_shadow[i] == key) begin
                    ans.found = 1'b1;
                    ans.position = i[ADDR_W-1:0];
                end else begin
                    lo = i / 2 + 1;
                    hi = i - 1;
                    if (hi > n - 1) hi = n - 1;
                    while (lo <= hi && !ans.found) begin
                        mid = lo + (hi - lo) / 2;
                        if (entries_shadow[mid] == key) begin
                            ans.found = 1'b1;
                            ans.position = mid[ADDR_W-1:0];
                        end else if (entries_shadow[mid] < key) begin
                            lo = mid + 1;
                        end else begin
                            hi = mid - 1;
                        end
                    end
                end
            end
        end
        return ans;
    endfunction

    // Offers one word and holds it until taken; the shadow state follows acceptance.
    task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                             input int wval, input int key);
        i_valid <= 1'b1;
        i_op <= op;
        i_entry_address <= addr;
        i_write_value <= wval;
        i_search_key <= key;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (op == OP_WRITE) entries_shadow[addr] = wval;
        else answers_due.push_back(predict_search(key));
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic write_entry(input int addr, input int wval);
        send_item(OP_WRITE, addr[ADDR_W-1:0], wval, $urandom);
    endtask

    task automatic look_up(input int key);
        send_item(OP_SEARCH, ADDR_W'($urandom_range(0, DEPTH - 1)), $urandom, key);
    endtask

    // Count changes only with the block drained and settled.
    task automatic set_entry_count(input int unsigned n);
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n[COUNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        count_shadow = n;
    endtask

    task automatic fill_sorted(input int n, input longint start, input int unsigned step_max);
        longint v;
        v = start;
        for (int i = 0; i < n; i++) begin
            if (v > KEY_MAX) v = KEY_MAX;
            write_entry(i, int'(v));
            v += $urandom_range(0, step_max);
        end
    endtask

    // Mostly keys present in the live part of the table, some neighbors,
    // some random keys, and a few stray writes that break the ordering.
    task automatic search_mix(input int n_items, input int eff);
        int pick;
        int key;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                write_entry($urandom_range(0, DEPTH - 1), $urandom);
            end else if (eff == 0 || pick < 20) begin
                look_up($urandom);
            end else begin
                key = entries_shadow[$urandom_range(0, eff - 1)];
                if (pick < 35) key = key + ($urandom_range(0, 1) ? 1 : -1);
                look_up(key);
            end
        end
    endtask

    task automatic test_empty_table();
        idle_pct = 30;
        stall_pct = 30;
        look_up(0);
        look_up(KEY_MIN);
        look_up(KEY_MAX);
    endtask

    task automatic test_small_table();
        int vals [8];
        vals = '{KEY_MIN, -5, 0, 0, 7, 100, KEY_MAX - 1, KEY_MAX};
        foreach (vals[i]) write_entry(i, vals[i]);
        set_entry_count(8);
        foreach (vals[i]) look_up(vals[i]);
        look_up(KEY_MIN + 1);
        look_up(1);
        look_up(101);
        look_up(KEY_MAX - 2);
    endtask

    task automatic test_clipped_count();
        set_entry_count(1);
        look_up(KEY_MIN);
        look_up(-5);
        set_entry_count(5);
        look_up(7);
        look_up(100);
        look_up(0);
    endtask

    task automatic test_unsorted();
        write_entry(2, 500);
        look_up(500);
        look_up(0);
        look_up(7);
        set_entry_count(8);
        look_up(100);
        look_up(KEY_MAX);
    endtask

    task automatic test_full_table();
        idle_pct = 15;
        stall_pct = 15;
        fill_sorted(DEPTH, KEY_MIN, 8388608);
        write_entry(DEPTH - 1, KEY_MAX);
        base_values = entries_shadow;
        set_entry_count(DEPTH);
        look_up(KEY_MAX);
        search_mix(20, DEPTH);
        // count above the depth saturates
        set_entry_count(2047);
        look_up(KEY_MAX);
        search_mix(10, DEPTH);
        set_entry_count(DEPTH - 1);
        look_up(KEY_MAX);
        search_mix(10, DEPTH - 1);
    endtask

    task automatic test_backpressure();
        set_entry_count(DEPTH);
        idle_pct = 0;
        long_hold_pending = 1'b1;
        search_mix(24, DEPTH);
    endtask

    task automatic test_random();
        int pick;
        int n;
        int eff;
        int unsigned spread;
        while (items_sent < ITEM_TARGET) begin
            idle_pct = $urandom_range(0, 3) * 15;
            stall_pct = $urandom_range(0, 3) * 15;
            if (items_sent > ITEM_TARGET - CALM_TAIL) calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                n = $urandom_range(1, PREFIX);
                set_entry_count(n);
                case ($urandom_range(0, 2))
                    0: spread = 3;
                    1: spread = 1000;
                    default: spread = 1 << 24;
                endcase
                fill_sorted(n, longint'(int'($urandom)) / 2, spread);
                prefix_dirty = 1'b1;
            end else begin
                if (pick < 85) n = $urandom_range(PREFIX + 1, DEPTH - 1);
                else if (pick < 90) n = DEPTH;
                else if (pick < 95) n = $urandom_range(DEPTH + 1, 2047);
                else n = $urandom_range(0, 1);
                set_entry_count(n);
                if (n > PREFIX && prefix_dirty) begin
                    for (int i = 0; i < PREFIX; i++) write_entry(i, base_values[i]);
                    prefix_dirty = 1'b0;
                end
            end
            eff = (n > DEPTH) ? DEPTH : n;
            search_mix($urandom_range(15, 40), eff);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_search_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                $error("unexpected result word: found %0d, position %0d", o_found, o_position);
                fail_count++;
            end else begin
                want = answers_due.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_found);
                    fail_count++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, actual %0d", want.position, o_position);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no word moving on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("exponential_search_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_small_table();
        test_clipped_count();
        test_unsorted();
        test_full_table();
        test_backpressure();
        test_random();
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("exponential_search_top: match");
        end else begin
            $display("exponential_search_top: mismatch");
        end
        $finish;
    end

endmodule
